/* rtl/plbc_pkg.sv */
// Shared constants and types for the prefixed line bound checker.
`default_nettype none

package plbc_pkg;

   localparam int FRAME_BYTES_DEFAULT = 256;
   localparam int PREFIX_BYTES = 8;

   localparam logic [3:0]  MAX_DEPTH_RESET    = 4'd8;
   localparam logic [63:0] FRAME_PREFIX_RESET = 64'h544F_4B4B_492F_3120;

   localparam logic [7:0] BYTE_LF        = 8'h0A;
   localparam logic [7:0] BYTE_NUL       = 8'h00;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_U         = 8'h75;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_LBRACE    = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE    = 8'h7D;
   localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;

   // Progress through the refused escape sequence.
   localparam logic [2:0] NUL_NONE      = 3'd0;
   localparam logic [2:0] NUL_BACKSLASH = 3'd1;
   localparam logic [2:0] NUL_U         = 3'd2;
   localparam logic [2:0] NUL_LAST      = 3'd5;

   localparam logic CSR_MAX_DEPTH    = 1'b0;
   localparam logic CSR_FRAME_PREFIX = 1'b1;

   typedef enum logic [1:0] {
      VERDICT_OK   = 2'd0,
      VERDICT_BAD  = 2'd1,
      VERDICT_DROP = 2'd2
   } verdict_type;

   typedef struct packed {
      logic [3:0] nest_depth;
      logic       inside_string;
      logic       escape_pending;
      logic [2:0] nul_progress;
      logic       payload_bad;
   } plbc_scan_type;

endpackage

`default_nettype wire

/* rtl/prefixed_line_json_bound_checker.sv */
// Top level of the prefixed line bound checker.
//
// Bytes enter on the req_ channel, one per transfer, and LF ends a line.
// A line whose first eight bytes equal frame_prefix is framed; its payload
// is checked for nesting, string closure and escapes as the bytes arrive.
// A framed line gives one result on the rsp_ channel: at its LF, or at the
// first NUL or overflow byte, after which the rest of the line is dropped.
// Unframed lines give no result.
// Throughput is one byte per cycle unless req_stall; line state is registered.
// A result from the byte that ends or drops the line is registered in the output
// register, or in the skid register when rsp_stall holds the output; req_stall
// rises only when both registers are full under rsp_stall.
// max_depth and frame_prefix are written through csr_, by the user only while
// idle; the block does not enforce it. Synchronous reset clears the line state,
// empties both result registers and restores the register reset values.
`default_nettype none

module prefixed_line_json_bound_checker
   import plbc_pkg::*;
#(
   parameter int FRAME_BYTES = FRAME_BYTES_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_verdict,
   output logic [7:0]  rsp_payload_length,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata
);

   localparam int LC_W  = $clog2(FRAME_BYTES);
   localparam int LEN_W = (LC_W > 8) ? LC_W : 8;

   logic [3:0]      max_depth_ff;
   logic [63:0]     frame_prefix_ff;
   logic [LC_W-1:0] line_count_ff, line_count_in;
   logic            discarding_ff, discarding_in;
   logic            prefix_ok_ff, prefix_ok_in;
   plbc_scan_type   scan_ff, scan_in, scan_step;

   logic            out_valid_ff, out_valid_in;
   logic [1:0]      out_verdict_ff, out_verdict_in;
   logic [7:0]      out_length_ff, out_length_in;
   logic            skid_valid_ff, skid_valid_in;
   logic [1:0]      skid_verdict_ff, skid_verdict_in;
   logic [7:0]      skid_length_ff, skid_length_in;

   logic            req_fire, out_free, framed, line_bad;
   logic            res_valid;
   logic [1:0]      res_verdict;
   logic [7:0]      res_length;
   logic [2:0]      prefix_idx;
   logic [5:0]      prefix_shift;
   logic [7:0]      prefix_want;
   logic [LEN_W-1:0] length_wide;

   plbc_payload u_payload (
      .scan      (scan_ff),
      .data_byte (req_data_byte),
      .max_depth (max_depth_ff),
      .scan_next (scan_step)
   );

   assign req_stall = skid_valid_ff;
   assign req_fire  = req_valid && !skid_valid_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;

   assign framed       = (line_count_ff >= LC_W'(PREFIX_BYTES)) && prefix_ok_ff;
   assign line_bad     = scan_ff.payload_bad || (scan_ff.nest_depth != 4'd0)
                         || scan_ff.inside_string || scan_ff.escape_pending;
   assign prefix_idx   = line_count_ff[2:0];
   assign prefix_shift = {~prefix_idx, 3'b000};
   assign prefix_want  = frame_prefix_ff[prefix_shift +: 8];
   assign length_wide  = LEN_W'(line_count_ff) - LEN_W'(PREFIX_BYTES);

   always_comb begin
      line_count_in = line_count_ff;
      discarding_in = discarding_ff;
      prefix_ok_in  = prefix_ok_ff;
      scan_in       = scan_ff;
      res_valid     = 1'b0;
      res_verdict   = VERDICT_OK;
      res_length    = 8'd0;
      if (req_fire) begin
         priority if (req_data_byte == BYTE_LF) begin
            res_valid     = !discarding_ff && framed;
            res_verdict   = line_bad ? VERDICT_BAD : VERDICT_OK;
            res_length    = length_wide[7:0];
            line_count_in = '0;
            discarding_in = 1'b0;
            prefix_ok_in  = 1'b1;
            scan_in       = '0;
         end else if (discarding_ff) begin
            line_count_in = line_count_ff;
         end else if (req_data_byte == BYTE_NUL
                      || line_count_ff >= LC_W'(FRAME_BYTES - 1)) begin
            discarding_in = 1'b1;
            res_valid     = framed;
            res_verdict   = VERDICT_DROP;
            res_length    = 8'd0;
         end else if (line_count_ff < LC_W'(PREFIX_BYTES)) begin
            if (prefix_want != req_data_byte) begin
               prefix_ok_in = 1'b0;
            end
            line_count_in = line_count_ff + LC_W'(1);
         end else begin
            scan_in       = scan_step;
            line_count_in = line_count_ff + LC_W'(1);
         end
      end
   end

   always_comb begin
      out_valid_in    = out_valid_ff;
      out_verdict_in  = out_verdict_ff;
      out_length_in   = out_length_ff;
      skid_valid_in   = skid_valid_ff;
      skid_verdict_in = skid_verdict_ff;
      skid_length_in  = skid_length_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in   = 1'b1;
            out_verdict_in = skid_verdict_ff;
            out_length_in  = skid_length_ff;
            skid_valid_in  = 1'b0;
         end else begin
            out_valid_in   = res_valid;
            out_verdict_in = res_verdict;
            out_length_in  = res_length;
         end
      end else if (res_valid) begin
         skid_valid_in   = 1'b1;
         skid_verdict_in = res_verdict;
         skid_length_in  = res_length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_depth_ff    <= MAX_DEPTH_RESET;
         frame_prefix_ff <= FRAME_PREFIX_RESET;
         line_count_ff   <= '0;
         discarding_ff   <= 1'b0;
         prefix_ok_ff    <= 1'b1;
         scan_ff         <= '0;
         out_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_MAX_DEPTH:    max_depth_ff    <= csr_wdata[3:0];
               CSR_FRAME_PREFIX: frame_prefix_ff <= csr_wdata;
               default:          max_depth_ff    <= max_depth_ff;
            endcase
         end
         line_count_ff <= line_count_in;
         discarding_ff <= discarding_in;
         prefix_ok_ff  <= prefix_ok_in;
         scan_ff       <= scan_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_verdict_ff  <= out_verdict_in;
      out_length_ff   <= out_length_in;
      skid_verdict_ff <= skid_verdict_in;
      skid_length_ff  <= skid_length_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_verdict        = out_verdict_ff;
   assign rsp_payload_length = out_length_ff;

endmodule

`default_nettype wire

/* rtl/plbc_payload.sv */
// Per-byte update of the payload nesting, string and escape checks.
`default_nettype none

module plbc_payload
   import plbc_pkg::*;
(
   input  plbc_scan_type scan,
   input  logic [7:0]    data_byte,
   input  logic [3:0]    max_depth,
   output plbc_scan_type scan_next
);

   logic in_zero_run;

   assign in_zero_run = (scan.nul_progress >= NUL_U);

   always_comb begin
      scan_next = scan;
      if (!scan.payload_bad) begin
         if (scan.inside_string) begin
            if (scan.escape_pending) begin
               scan_next.escape_pending = 1'b0;
               scan_next.nul_progress =
                  (scan.nul_progress == NUL_BACKSLASH && data_byte == CHAR_U) ? NUL_U : NUL_NONE;
            end else if (in_zero_run && data_byte == CHAR_ZERO) begin
               if (scan.nul_progress >= NUL_LAST) begin
                  scan_next.payload_bad  = 1'b1;
                  scan_next.nul_progress = NUL_NONE;
               end else begin
                  scan_next.nul_progress = scan.nul_progress + 3'd1;
               end
            end else begin
               if (in_zero_run) begin
                  scan_next.nul_progress = NUL_NONE;
               end
               if (data_byte == CHAR_BACKSLASH) begin
                  scan_next.escape_pending = 1'b1;
                  scan_next.nul_progress   = NUL_BACKSLASH;
               end else if (data_byte == CHAR_QUOTE) begin
                  scan_next.inside_string = 1'b0;
               end
            end
         end else begin
            if (data_byte == CHAR_QUOTE) begin
               scan_next.inside_string = 1'b1;
            end else if (data_byte == CHAR_LBRACE || data_byte == CHAR_LBRACKET) begin
               if (scan.nest_depth >= max_depth) begin
                  scan_next.payload_bad = 1'b1;
               end else begin
                  scan_next.nest_depth = scan.nest_depth + 4'd1;
               end
            end else if (data_byte == CHAR_RBRACE || data_byte == CHAR_RBRACKET) begin
               if (scan.nest_depth == 4'd0) begin
                  scan_next.payload_bad = 1'b1;
               end else begin
                  scan_next.nest_depth = scan.nest_depth - 4'd1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/plbc_checker.sv */
// Port-level assertions for the prefixed line bound checker, with its bind.
`default_nettype none

module plbc_checker
   import plbc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_verdict,
   input logic [7:0] rsp_payload_length
);

   // A result that waits under stall keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_verdict)
      && $stable(rsp_payload_length))
      else $error("stalled result changed");

   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_verdict == VERDICT_OK || rsp_verdict == VERDICT_BAD
      || rsp_verdict == VERDICT_DROP)
      else $error("result carries an unused verdict code");

   a_drop_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict == VERDICT_DROP |-> rsp_payload_length == 8'd0)
      else $error("dropped line reports a nonzero length");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result registers not empty after reset");

   // Input stalls only when a result already waits at the output.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

endmodule

bind prefixed_line_json_bound_checker plbc_checker u_plbc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_verdict        (rsp_verdict),
   .rsp_payload_length (rsp_payload_length)
);

`default_nettype wire

/* sim/prefixed_line_json_bound_checker_test.sv */
// Self-checking testbench for the prefixed line bound checker.

module prefixed_line_json_bound_checker_test;
   import plbc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [7:0] byte_queue_type[$];

   typedef struct packed {
      verdict_type verdict;
      logic [7:0]  length;
   } line_result_type;

   typedef enum bit {
      ROW_LINE,
      ROW_WRITE
   } row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic        csr_idx;
      logic [63:0] csr_data;
      bit          framed;
      string       body;
      bit          with_nul;
      int          pad;
      bit          typed;
      verdict_type verdict;
      logic [7:0]  length;
   } line_case_type;

   localparam logic [7:0] CHAR_PAD = 8'h61;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_stall = 1'b0;
   logic        csr_write = 1'b0;
   logic        csr_index = 1'b0;
   logic [63:0] csr_wdata = 64'h0;
   wire         req_stall;
   wire         rsp_valid;
   wire  [1:0]  rsp_verdict;
   wire  [7:0]  rsp_payload_length;

   // Line state of the checker as predicted from the accepted bytes.
   logic [3:0]  depth_cfg = MAX_DEPTH_RESET;
   logic [63:0] prefix_cfg = FRAME_PREFIX_RESET;
   int          line_len = 0;
   bit          dropping = 1'b0;
   bit          prefix_match = 1'b1;
   int          nest = 0;
   bit          quoted = 1'b0;
   bit          escaped = 1'b0;
   logic [2:0]  nul_prog = NUL_NONE;
   bit          scan_bad = 1'b0;

   line_result_type pending_results[$];
   line_result_type typed_result;
   bit              typed_armed = 1'b0;
   byte_queue_type  line_bytes;
   line_case_type   cases[$];

   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_left = 0;
   int errors = 0;
   int bytes_in = 0;
   int results_due = 0;
   int lines_sent = 0;
   int writes_done = 0;
   int seen_ok = 0;
   int seen_bad = 0;
   int seen_drop = 0;

   prefixed_line_json_bound_checker u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_verdict        (rsp_verdict),
      .rsp_payload_length (rsp_payload_length),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #1ms;
      $display("FAIL prefixed_line_json_bound_checker");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      errors++;
   endtask

   // Returns 1 when the byte closes or drops a framed line.
   function automatic bit predict_line_byte(input logic [7:0] c, output verdict_type v,
                                            output logic [7:0] len);
      bit framed;
      bit handled;
      framed = (line_len >= PREFIX_BYTES) && prefix_match;
      v = VERDICT_OK;
      len = 8'h00;
      if (c == BYTE_LF) begin
         predict_line_byte = 1'b0;
         if (!dropping && framed) begin
            v = (scan_bad || nest != 0 || quoted || escaped) ? VERDICT_BAD : VERDICT_OK;
            len = 8'(line_len - PREFIX_BYTES);
            predict_line_byte = 1'b1;
         end
         line_len = 0;
         dropping = 1'b0;
         prefix_match = 1'b1;
         nest = 0;
         quoted = 1'b0;
         escaped = 1'b0;
         nul_prog = NUL_NONE;
         scan_bad = 1'b0;
         return predict_line_byte;
      end
      if (dropping) return 1'b0;
      if (c == BYTE_NUL || line_len >= FRAME_BYTES_DEFAULT - 1) begin
         dropping = 1'b1;
         if (framed) begin
            v = VERDICT_DROP;
            return 1'b1;
         end
         return 1'b0;
      end
      if (line_len < PREFIX_BYTES) begin
         if (prefix_cfg[8 * (PREFIX_BYTES - 1 - line_len) +: 8] != c) prefix_match = 1'b0;
      end else if (!scan_bad) begin
         if (quoted) begin
            if (escaped) begin
               escaped = 1'b0;
               nul_prog = (nul_prog == NUL_BACKSLASH && c == CHAR_U) ? NUL_U : NUL_NONE;
            end else begin
               handled = 1'b0;
               if (nul_prog >= NUL_U) begin
                  if (c == CHAR_ZERO) begin
                     handled = 1'b1;
                     if (nul_prog >= NUL_LAST) begin
                        scan_bad = 1'b1;
                        nul_prog = NUL_NONE;
                     end else begin
                        nul_prog = nul_prog + 3'd1;
                     end
                  end else begin
                     nul_prog = NUL_NONE;
                  end
               end
               if (!handled) begin
                  if (c == CHAR_BACKSLASH) begin
                     escaped = 1'b1;
                     nul_prog = NUL_BACKSLASH;
                  end else if (c == CHAR_QUOTE) begin
                     quoted = 1'b0;
                  end
               end
            end
         end else if (c == CHAR_QUOTE) begin
            quoted = 1'b1;
         end else if (c == CHAR_LBRACE || c == CHAR_LBRACKET) begin
            if (nest >= depth_cfg) scan_bad = 1'b1;
            else nest++;
         end else if (c == CHAR_RBRACE || c == CHAR_RBRACKET) begin
            if (nest == 0) scan_bad = 1'b1;
            else nest--;
         end
      end
      line_len++;
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      verdict_type     v;
      logic [7:0]      len;
      line_result_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            bytes_in++;
            if (predict_line_byte(req_data_byte, v, len)) begin
               if (typed_armed) begin
                  pending_results.push_back(typed_result);
                  typed_armed = 1'b0;
               end else begin
                  pending_results.push_back('{verdict: v, length: len});
               end
               results_due++;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("result transfer with nothing expected: verdict %0d length %0d",
                                         rsp_verdict, rsp_payload_length));
            end else begin
               want = pending_results.pop_front();
               case (want.verdict)
                  VERDICT_OK:  seen_ok++;
                  VERDICT_BAD: seen_bad++;
                  default:     seen_drop++;
               endcase
               if (rsp_verdict !== want.verdict)
                  report_mismatch($sformatf("verdict %0d, expected %0d", rsp_verdict, want.verdict));
               if (rsp_payload_length !== want.length)
                  report_mismatch($sformatf("payload_length %0d, expected %0d",
                                            rsp_payload_length, want.length));
            end
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_line();
      foreach (line_bytes[i]) send_byte(line_bytes[i]);
      line_bytes.delete();
      lines_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [63:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_MAX_DEPTH) depth_cfg = data[3:0];
      else prefix_cfg = data;
      writes_done++;
      @(posedge clock);
   endtask

   task automatic push_prefix();
      for (int i = 0; i < PREFIX_BYTES; i++)
         line_bytes.push_back(prefix_cfg[8 * (PREFIX_BYTES - 1 - i) +: 8]);
   endtask

   task automatic add_quoted_text();
      int n;
      line_bytes.push_back(CHAR_QUOTE);
      n = $urandom_range(6);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(11))
            0: line_bytes = {line_bytes, CHAR_BACKSLASH, CHAR_U, CHAR_ZERO, CHAR_ZERO,
                             CHAR_ZERO, CHAR_ZERO};
            1: line_bytes = {line_bytes, CHAR_BACKSLASH, CHAR_U, CHAR_ZERO, CHAR_ZERO,
                             CHAR_ZERO, CHAR_PAD};
            2: line_bytes = {line_bytes, CHAR_BACKSLASH, CHAR_QUOTE};
            3: line_bytes = {line_bytes, CHAR_BACKSLASH, CHAR_BACKSLASH};
            4: line_bytes = {line_bytes, CHAR_BACKSLASH, CHAR_ZERO};
            5: line_bytes.push_back(8'($urandom_range(128, 255)));
            6: line_bytes.push_back($urandom_range(1) ? CHAR_LBRACE : CHAR_RBRACKET);
            default: line_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
         endcase
      end
      line_bytes.push_back(CHAR_QUOTE);
   endtask

   // Appends well-formed nesting within the current depth limit.
   task automatic add_json_body(input int tokens);
      logic [7:0] closers[$];
      for (int i = 0; i < tokens; i++) begin
         case ($urandom_range(9))
            0, 1, 2: begin
               if (closers.size() < depth_cfg) begin
                  if ($urandom_range(1)) begin
                     line_bytes.push_back(CHAR_LBRACE);
                     closers.push_back(CHAR_RBRACE);
                  end else begin
                     line_bytes.push_back(CHAR_LBRACKET);
                     closers.push_back(CHAR_RBRACKET);
                  end
               end
            end
            3, 4: begin
               if (closers.size() > 0) line_bytes.push_back(closers.pop_back());
            end
            5, 6, 7: add_quoted_text();
            default: line_bytes.push_back(8'(CHAR_ZERO + $urandom_range(9)));
         endcase
      end
      while (closers.size() > 0) line_bytes.push_back(closers.pop_back());
   endtask

   task automatic send_random_line();
      logic [7:0] specials[6];
      int         pos;
      int         pick;
      int         target;
      specials = '{CHAR_QUOTE, CHAR_BACKSLASH, CHAR_LBRACE, CHAR_RBRACE, CHAR_LBRACKET,
                   CHAR_RBRACKET};
      pick = $urandom_range(99);
      if (pick < 60) begin
         push_prefix();
         add_json_body($urandom_range(0, 10));
      end else if (pick < 75) begin
         push_prefix();
         add_json_body($urandom_range(0, 10));
         pos = $urandom_range(PREFIX_BYTES, line_bytes.size());
         case ($urandom_range(3))
            0, 1: line_bytes.insert(pos, specials[$urandom_range(5)]);
            2: if (pos < line_bytes.size()) line_bytes.delete(pos);
            default: while (line_bytes.size() > pos) void'(line_bytes.pop_back());
         endcase
      end else if (pick < 83) begin
         push_prefix();
         if ($urandom_range(1)) begin
            pos = $urandom_range(PREFIX_BYTES - 1);
            line_bytes[pos] = line_bytes[pos] ^ 8'($urandom_range(1, 255));
            add_json_body($urandom_range(0, 4));
         end else begin
            while (line_bytes.size() > $urandom_range(1, PREFIX_BYTES - 1))
               void'(line_bytes.pop_back());
         end
      end else if (pick < 90) begin
         target = $urandom_range(1, 24);
         for (int i = 0; i < target; i++) line_bytes.push_back(8'($urandom_range(255)));
      end else if (pick < 95) begin
         push_prefix();
         add_json_body($urandom_range(0, 6));
         line_bytes.insert($urandom_range(PREFIX_BYTES, line_bytes.size()), BYTE_NUL);
         add_json_body($urandom_range(0, 3));
      end else begin
         push_prefix();
         add_json_body($urandom_range(0, 6));
         target = $urandom_range(16, 40);
         while (line_bytes.size() < PREFIX_BYTES + target) line_bytes.push_back(CHAR_PAD);
      end
      line_bytes.push_back(BYTE_LF);
      send_line();
   endtask

   function automatic line_case_type text_row(input bit framed, input string body,
                                              input bit with_nul = 1'b0, input int pad = 0,
                                              input bit typed = 1'b0,
                                              input verdict_type v = VERDICT_OK,
                                              input int len = 0);
      line_case_type r;
      r.kind = ROW_LINE;
      r.csr_idx = CSR_MAX_DEPTH;
      r.csr_data = 64'h0;
      r.framed = framed;
      r.body = body;
      r.with_nul = with_nul;
      r.pad = pad;
      r.typed = typed;
      r.verdict = v;
      r.length = 8'(len);
      return r;
   endfunction

   function automatic line_case_type write_row(input logic idx, input logic [63:0] data);
      line_case_type r;
      r = text_row(1'b0, "");
      r.kind = ROW_WRITE;
      r.csr_idx = idx;
      r.csr_data = data;
      return r;
   endfunction

   initial begin
      int          phase_bytes;
      int          phase_results;
      logic [63:0] prefix;
      logic [7:0]  b;

      cases.push_back(text_row(1, "", 0, 0, 1, VERDICT_OK, 0));
      cases.push_back(text_row(1, "{\"a\":[1,2]}", 0, 0, 1, VERDICT_OK, 11));
      cases.push_back(text_row(1, "}", 0, 0, 1, VERDICT_BAD, 1));
      cases.push_back(text_row(1, "[[", 0, 0, 1, VERDICT_BAD, 2));
      cases.push_back(text_row(1, "\"abc", 0, 0, 1, VERDICT_BAD, 4));
      cases.push_back(text_row(1, "\"a\\", 0, 0, 1, VERDICT_BAD, 3));
      cases.push_back(text_row(1, "\"\\u0000\"", 0, 0, 1, VERDICT_BAD, 8));
      cases.push_back(text_row(1, "\"\\u000\""));
      cases.push_back(text_row(1, "\"\\\\u0000\""));
      cases.push_back(text_row(1, "\"\\\"}\""));
      cases.push_back(text_row(1, "]{", 0, 0, 1, VERDICT_BAD, 2));
      cases.push_back(text_row(1, "{{{{{{{{}}}}}}}}", 0, 0, 1, VERDICT_OK, 16));
      cases.push_back(text_row(1, "{{{{{{{{{}}}}}}}}}"));
      cases.push_back(text_row(0, "abc"));
      cases.push_back(text_row(0, "abcdefgh{}"));
      cases.push_back(text_row(1, "{", 1, 5, 1, VERDICT_DROP, 0));
      cases.push_back(text_row(0, "ab", 1, 3));
      cases.push_back(text_row(1, "", 0, 247, 1, VERDICT_OK, 247));
      cases.push_back(text_row(1, "", 0, 248, 1, VERDICT_DROP, 0));
      cases.push_back(text_row(1, "\377\200", 0, 0, 1, VERDICT_OK, 2));
      cases.push_back(write_row(CSR_MAX_DEPTH, 64'd0));
      cases.push_back(text_row(1, "[", 0, 0, 1, VERDICT_BAD, 1));
      cases.push_back(text_row(1, "\"{\"", 0, 0, 1, VERDICT_OK, 3));
      cases.push_back(write_row(CSR_MAX_DEPTH, 64'd15));
      cases.push_back(text_row(1, "[[[[[[[[[[[[[[[]]]]]]]]]]]]]]]"));
      cases.push_back(text_row(1, "[[[[[[[[[[[[[[[{}]]]]]]]]]]]]]]]"));
      cases.push_back(write_row(CSR_FRAME_PREFIX, 64'h0));
      cases.push_back(text_row(1, "{}"));
      cases.push_back(write_row(CSR_FRAME_PREFIX, '1));
      cases.push_back(text_row(1, "{}", 0, 0, 1, VERDICT_OK, 2));
      cases.push_back(text_row(1, "x", 1, 2, 1, VERDICT_DROP, 0));

      send_idle_pct = 34;
      rsp_idle_pct = 64;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (cases[i]) begin
         if (cases[i].kind == ROW_WRITE) begin
            wait_idle();
            write_csr(cases[i].csr_idx, cases[i].csr_data);
         end else begin
            if (cases[i].framed) push_prefix();
            for (int k = 0; k < cases[i].body.len(); k++) line_bytes.push_back(cases[i].body[k]);
            if (cases[i].with_nul) line_bytes.push_back(BYTE_NUL);
            repeat (cases[i].pad) line_bytes.push_back(CHAR_PAD);
            line_bytes.push_back(BYTE_LF);
            typed_result <= '{verdict: cases[i].verdict, length: cases[i].length};
            typed_armed <= cases[i].typed;
            send_line();
         end
      end

      for (int phase = 0; phase < 3; phase++) begin
         wait_idle();
         typed_armed <= 1'b0;
         send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 64 : 0;
         rsp_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 34 : 0;
         write_csr(CSR_MAX_DEPTH, 64'($urandom_range(1, 15)));
         for (int i = 0; i < PREFIX_BYTES; i++) begin
            do b = 8'($urandom_range(1, 255)); while (b == BYTE_LF);
            prefix = {prefix[55:0], b};
         end
         write_csr(CSR_FRAME_PREFIX, prefix);
         phase_bytes = bytes_in;
         phase_results = results_due;
         if (phase == 2) begin
            // Long receiver hold-off while short framed lines keep arriving.
            hold_left = 200;
            repeat (8) begin
               push_prefix();
               line_bytes = {line_bytes, CHAR_LBRACE, CHAR_RBRACE, BYTE_LF};
               send_line();
            end
         end
         while (bytes_in - phase_bytes < 40 || results_due - phase_results < 2)
            send_random_line();
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Run covered %0d bytes in %0d lines with %0d register writes and three idle patterns.",
               bytes_in, lines_sent, writes_done);
      $display("Checked %0d results: %0d accepted, %0d bad nesting or escape, %0d dropped.",
               seen_ok + seen_bad + seen_drop, seen_ok, seen_bad, seen_drop);
      if (errors == 0) begin
         $display("PASS prefixed_line_json_bound_checker");
      end else begin
         $display("FAIL prefixed_line_json_bound_checker");
      end
      $finish;
   end

endmodule
